@@ hw/rtl/tlac_pkg.sv @@
// tlac_pkg: shared types and codes for the timed lift actuator controller.
// Transfer structs, configuration block, register indexes and drive/status codes.
// No dependencies.
`timescale 1ns / 1ps

package tlac_pkg;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] C_REG_CURRENT_LIMIT = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] C_REG_OC_HOLD       = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] C_REG_MOVE_DURATION = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] C_REG_SETTLE_DELAY  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] C_REG_REVERSE_DIR   = 3'd4;

    localparam logic [15:0] C_RST_CURRENT_LIMIT = 16'd2000;
    localparam logic [15:0] C_RST_OC_HOLD       = 16'd1000;
    localparam logic [15:0] C_RST_MOVE_DURATION = 16'd9000;
    localparam logic [15:0] C_RST_SETTLE_DELAY  = 16'd2000;

    localparam logic C_CMD_RAISE = 1'b0;
    localparam logic C_CMD_LOWER = 1'b1;

    localparam logic [1:0] C_DRIVE_STOP = 2'd0;
    localparam logic [1:0] C_DRIVE_DIR1 = 2'd1;
    localparam logic [1:0] C_DRIVE_DIR2 = 2'd2;

    localparam logic [1:0] C_STATUS_RAISED  = 2'd0;
    localparam logic [1:0] C_STATUS_LOWERED = 2'd1;
    localparam logic [1:0] C_STATUS_MOVING  = 2'd2;

    typedef struct packed {
        logic [31:0] now_ms;
        logic [15:0] motor_current_raw;
        logic        lift_command;
        logic        key_off;
        logic        emergency_stop;
    } t_in_item;

    typedef struct packed {
        logic [1:0] drive_code;
        logic [1:0] position_status;
        logic       overcurrent;
    } t_out_item;

    typedef struct packed {
        logic [15:0] current_limit_ma;
        logic [15:0] overcurrent_hold_ms;
        logic [15:0] move_duration_ms;
        logic [15:0] settle_delay_ms;
        logic        reverse_direction;
    } t_cfg;

endpackage

@@ hw/rtl/tlac_step.sv @@
// tlac_step: controller state and the per-step update (overcurrent, key-off, move timing).
// Depends on tlac_pkg.
`timescale 1ns / 1ps

module tlac_step (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  tlac_pkg::t_in_item i_item,
    input  tlac_pkg::t_cfg    i_cfg,
    output tlac_pkg::t_out_item o_result
);

    logic        r_move_done;
    logic        r_active;
    logic [31:0] r_move_start;
    logic [31:0] r_below_limit;
    logic        r_fault;
    logic [1:0]  r_drive;
    logic [1:0]  r_status;

    logic        n_move_done;
    logic        n_active;
    logic [31:0] n_move_start;
    logic [31:0] n_below_limit;
    logic        n_fault;
    logic [1:0]  n_drive;
    logic [1:0]  n_status;

    logic [18:0] current_ma;
    logic [31:0] above_time;
    logic [31:0] elapsed;
    logic [31:0] settle_elapsed;
    logic        cmd;

    always_comb begin
        n_move_done   = r_move_done;
        n_active      = r_active;
        n_move_start  = r_move_start;
        n_below_limit = r_below_limit;
        n_fault       = r_fault;
        n_drive       = r_drive;
        n_status      = r_status;

        current_ma = ({3'b000, i_item.motor_current_raw} << 2)
                   + {3'b000, i_item.motor_current_raw};
        above_time = i_item.now_ms - r_below_limit;
        if (current_ma > {3'b000, i_cfg.current_limit_ma}) begin
            if (above_time > {16'd0, i_cfg.overcurrent_hold_ms}) begin
                n_fault = 1'b1;
            end
        end else begin
            n_below_limit = i_item.now_ms;
        end

        cmd = i_item.lift_command;
        if (i_item.key_off && !i_item.emergency_stop) begin
            cmd = tlac_pkg::C_CMD_RAISE;
        end

        if (r_move_done && (r_active != cmd)) begin
            n_move_done  = 1'b0;
            n_active     = cmd;
            n_move_start = i_item.now_ms;
            n_status     = tlac_pkg::C_STATUS_MOVING;
        end

        elapsed = i_item.now_ms - n_move_start;
        if (!n_move_done && (elapsed <= {16'd0, i_cfg.move_duration_ms})) begin
            if (i_item.emergency_stop) begin
                if (r_drive != tlac_pkg::C_DRIVE_STOP) begin
                    n_active = tlac_pkg::C_CMD_RAISE;
                end
                n_drive      = tlac_pkg::C_DRIVE_STOP;
                n_move_start = i_item.now_ms;
            end else if ((n_active == tlac_pkg::C_CMD_LOWER) != i_cfg.reverse_direction) begin
                n_drive = tlac_pkg::C_DRIVE_DIR2;
            end else begin
                n_drive = tlac_pkg::C_DRIVE_DIR1;
            end
            settle_elapsed = i_item.now_ms - n_move_start;
            if (settle_elapsed > {16'd0, i_cfg.settle_delay_ms}) begin
                n_status = (n_active == tlac_pkg::C_CMD_LOWER) ? tlac_pkg::C_STATUS_LOWERED
                                                               : tlac_pkg::C_STATUS_RAISED;
            end
        end else begin
            settle_elapsed = elapsed;
            n_move_done    = 1'b1;
            n_drive        = tlac_pkg::C_DRIVE_STOP;
            n_status       = (n_active == tlac_pkg::C_CMD_LOWER) ? tlac_pkg::C_STATUS_LOWERED
                                                                 : tlac_pkg::C_STATUS_RAISED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_move_done   <= 1'b0;
            r_active      <= tlac_pkg::C_CMD_LOWER;
            r_move_start  <= '0;
            r_below_limit <= '0;
            r_fault       <= 1'b0;
            r_drive       <= tlac_pkg::C_DRIVE_STOP;
            r_status      <= tlac_pkg::C_STATUS_RAISED;
        end else if (i_en) begin
            r_move_done   <= n_move_done;
            r_active      <= n_active;
            r_move_start  <= n_move_start;
            r_below_limit <= n_below_limit;
            r_fault       <= n_fault;
            r_drive       <= n_drive;
            r_status      <= n_status;
        end
    end

    assign o_result.drive_code      = n_drive;
    assign o_result.position_status = n_status;
    assign o_result.overcurrent     = n_fault;

    a_fault_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fault |=> r_fault)
        else $error("overcurrent fault cleared without reset");

    a_done_stopped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_move_done |-> (r_drive == tlac_pkg::C_DRIVE_STOP))
        else $error("drive running after move finished");

    a_no_drive_code3: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_drive != 2'd3)
        else $error("illegal drive code held");

endmodule

@@ hw/rtl/timed_lift_actuator_controller_core.sv @@
// timed_lift_actuator_controller_core: top level with input/result registers and config regs.
// Depends on tlac_pkg and tlac_step.
`timescale 1ns / 1ps

// Each item passes through the input register, then the result register, before its result transfer.
// Throughput: one item per cycle while the result is not stalled; the controller state updates once per item.
// Input stalls only while both stages hold items and the result is stalled.
// Reset (synchronous, active low): config regs to defaults, controller state to an
// unfinished lower move started at time 0, both pipeline stages empty.

module timed_lift_actuator_controller_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  tlac_pkg::t_in_item                    i_in_data,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output tlac_pkg::t_out_item                   o_out_data,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [tlac_pkg::CFG_INDEX_W-1:0]      i_cfg_index,
    input  logic [tlac_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    tlac_pkg::t_cfg      r_cfg;
    logic                r_in_valid;
    tlac_pkg::t_in_item  r_in_data;
    logic                r_out_valid;
    tlac_pkg::t_out_item r_out_data;
    tlac_pkg::t_out_item step_result;
    logic                out_load;
    logic                in_load;
    logic                step_en;

    assign out_load    = !r_out_valid || !i_out_stall;
    assign step_en     = r_in_valid && out_load;
    assign in_load     = !r_in_valid || out_load;
    assign o_in_stall  = !in_load;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.current_limit_ma    <= tlac_pkg::C_RST_CURRENT_LIMIT;
            r_cfg.overcurrent_hold_ms <= tlac_pkg::C_RST_OC_HOLD;
            r_cfg.move_duration_ms    <= tlac_pkg::C_RST_MOVE_DURATION;
            r_cfg.settle_delay_ms     <= tlac_pkg::C_RST_SETTLE_DELAY;
            r_cfg.reverse_direction   <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                tlac_pkg::C_REG_CURRENT_LIMIT: r_cfg.current_limit_ma    <= i_cfg_data;
                tlac_pkg::C_REG_OC_HOLD:       r_cfg.overcurrent_hold_ms <= i_cfg_data;
                tlac_pkg::C_REG_MOVE_DURATION: r_cfg.move_duration_ms    <= i_cfg_data;
                tlac_pkg::C_REG_SETTLE_DELAY:  r_cfg.settle_delay_ms     <= i_cfg_data;
                tlac_pkg::C_REG_REVERSE_DIR:   r_cfg.reverse_direction   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_load) begin
                r_in_valid <= i_in_valid;
            end
            if (out_load) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load && i_in_valid) begin
            r_in_data <= i_in_data;
        end
        if (step_en) begin
            r_out_data <= step_result;
        end
    end

    tlac_step u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (step_en),
        .i_item   (r_in_data),
        .i_cfg    (r_cfg),
        .o_result (step_result)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid))
        else $error("input stalled with free pipeline stage");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.position_status != 2'd3))
        else $error("illegal run status in result");

    a_drain_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !i_out_stall) |=> o_out_valid)
        else $error("pending item not moved to result register");

endmodule

@@ sim/tb_timed_lift_actuator_controller_core.sv @@
// tb_timed_lift_actuator_controller_core: self-checking bench for the lift actuator controller.
// Predicts drive, status and overcurrent per control step and checks every result transfer.
// Depends on tlac_pkg and timed_lift_actuator_controller_core.
`timescale 1ns / 1ps

module tb_timed_lift_actuator_controller_core;

    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam int unsigned MAX_REPORTS    = 10;
    localparam logic [18:0] MA_PER_RAW     = 19'd5;

    logic                             i_clk;
    logic                             i_rst_n     = 1'b0;
    logic                             i_in_valid  = 1'b0;
    logic                             o_in_stall;
    tlac_pkg::t_in_item               i_in_data   = '0;
    logic                             o_out_valid;
    logic                             i_out_stall = 1'b0;
    tlac_pkg::t_out_item              o_out_data;
    logic                             i_cfg_valid = 1'b0;
    logic                             o_cfg_ready;
    logic [tlac_pkg::CFG_INDEX_W-1:0] i_cfg_index = tlac_pkg::C_REG_CURRENT_LIMIT;
    logic [tlac_pkg::CFG_DATA_W-1:0]  i_cfg_data  = '0;

    // controller shadow state
    tlac_pkg::t_cfg lift_cfg = {tlac_pkg::C_RST_CURRENT_LIMIT, tlac_pkg::C_RST_OC_HOLD,
                                tlac_pkg::C_RST_MOVE_DURATION, tlac_pkg::C_RST_SETTLE_DELAY,
                                1'b0};
    logic        lift_done     = 1'b0;
    logic        lift_cmd      = tlac_pkg::C_CMD_LOWER;
    logic [31:0] lift_start_ms = '0;
    logic [31:0] lift_below_ms = '0;
    logic        lift_fault    = 1'b0;
    logic [1:0]  lift_drive    = tlac_pkg::C_DRIVE_STOP;
    logic [1:0]  lift_status   = tlac_pkg::C_STATUS_RAISED;

    tlac_pkg::t_out_item pending_lift_out[$];
    int unsigned mismatch_count = 0;
    int unsigned quiet_cycles   = 0;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_idle_pct  = 0;
    logic [31:0] step_clock_ms  = '0;
    logic        step_cmd       = tlac_pkg::C_CMD_LOWER;
    logic        fault_allowed  = 1'b0;

    timed_lift_actuator_controller_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic tlac_pkg::t_out_item predict_lift_step(input tlac_pkg::t_in_item step);
        logic [18:0] load_ma;
        logic        want_cmd;
        logic [1:0]  lower_code;
        logic [1:0]  raise_code;
        logic [31:0] elapsed;
        tlac_pkg::t_out_item res;
        load_ma  = 19'(step.motor_current_raw) * MA_PER_RAW;
        want_cmd = step.lift_command;
        if (load_ma > 19'(lift_cfg.current_limit_ma)) begin
            elapsed = step.now_ms - lift_below_ms;
            if (elapsed > 32'(lift_cfg.overcurrent_hold_ms))
                lift_fault = 1'b1;
        end else begin
            lift_below_ms = step.now_ms;
        end
        if (step.key_off && !step.emergency_stop)
            want_cmd = tlac_pkg::C_CMD_RAISE;
        if (lift_done && lift_cmd != want_cmd) begin
            lift_done     = 1'b0;
            lift_cmd      = want_cmd;
            lift_start_ms = step.now_ms;
            lift_status   = tlac_pkg::C_STATUS_MOVING;
        end
        elapsed = step.now_ms - lift_start_ms;
        if (!lift_done && elapsed <= 32'(lift_cfg.move_duration_ms)) begin
            if (step.emergency_stop) begin
                if (lift_drive != tlac_pkg::C_DRIVE_STOP)
                    lift_cmd = tlac_pkg::C_CMD_RAISE;
                lift_drive    = tlac_pkg::C_DRIVE_STOP;
                lift_start_ms = step.now_ms;
            end else begin
                lower_code = lift_cfg.reverse_direction ? tlac_pkg::C_DRIVE_DIR1
                                                        : tlac_pkg::C_DRIVE_DIR2;
                raise_code = lift_cfg.reverse_direction ? tlac_pkg::C_DRIVE_DIR2
                                                        : tlac_pkg::C_DRIVE_DIR1;
                lift_drive = (lift_cmd == tlac_pkg::C_CMD_LOWER) ? lower_code : raise_code;
            end
            elapsed = step.now_ms - lift_start_ms;
            if (elapsed > 32'(lift_cfg.settle_delay_ms))
                lift_status = (lift_cmd == tlac_pkg::C_CMD_LOWER) ? tlac_pkg::C_STATUS_LOWERED
                                                                  : tlac_pkg::C_STATUS_RAISED;
        end else begin
            lift_done   = 1'b1;
            lift_drive  = tlac_pkg::C_DRIVE_STOP;
            lift_status = (lift_cmd == tlac_pkg::C_CMD_LOWER) ? tlac_pkg::C_STATUS_LOWERED
                                                              : tlac_pkg::C_STATUS_RAISED;
        end
        res.drive_code      = lift_drive;
        res.position_status = lift_status;
        res.overcurrent     = lift_fault;
        return res;
    endfunction

    function automatic tlac_pkg::t_in_item step_item(input logic [31:0] now_ms,
                                                     input logic [15:0] raw,
                                                     input logic cmd, input logic key_off,
                                                     input logic estop);
        return {now_ms, raw, cmd, key_off, estop};
    endfunction

    function automatic tlac_pkg::t_cfg make_cfg(input logic [15:0] limit_ma,
                                                input logic [15:0] hold_ms,
                                                input logic [15:0] move_ms,
                                                input logic [15:0] settle_ms,
                                                input logic reverse);
        return {limit_ma, hold_ms, move_ms, settle_ms, reverse};
    endfunction

    // Well-formed time sequences with occasional jumps; current kept clear of the
    // fault unless the phase allows it.
    function automatic tlac_pkg::t_in_item make_random_step();
        tlac_pkg::t_in_item step;
        int unsigned pick;
        int unsigned span;
        int unsigned edge_raw;
        logic [31:0] since_below;
        span = 32'(lift_cfg.move_duration_ms) + 32'(lift_cfg.settle_delay_ms) + 100;
        pick = $urandom_range(99);
        if (pick < 65)
            step_clock_ms = step_clock_ms + $urandom_range(span / 4 + 10);
        else if (pick < 85)
            step_clock_ms = step_clock_ms + $urandom_range(2 * span);
        else if (pick < 97)
            step_clock_ms = step_clock_ms + (pick < 93 ? 32'd0 : 32'($urandom_range(span + 1)));
        else
            step_clock_ms = $urandom();
        if ($urandom_range(99) < 25)
            step_cmd = ~step_cmd;
        step.now_ms         = step_clock_ms;
        step.lift_command   = step_cmd;
        step.key_off        = ($urandom_range(99) < 12);
        step.emergency_stop = ($urandom_range(99) < 12);
        edge_raw    = 32'(lift_cfg.current_limit_ma) / 5;
        since_below = step_clock_ms - lift_below_ms;
        if ($urandom_range(99) < 30 &&
            (fault_allowed || since_below <= 32'(lift_cfg.overcurrent_hold_ms)))
            step.motor_current_raw = $urandom_range(1) ? 16'(edge_raw + 1)
                                                        : 16'($urandom_range(65535, edge_raw + 1));
        else
            step.motor_current_raw = $urandom_range(1) ? 16'(edge_raw)
                                                        : 16'($urandom_range(edge_raw));
        return step;
    endfunction

    task automatic flag_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
    endtask

    task automatic send_step(input tlac_pkg::t_in_item step);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= step;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pending_lift_out.push_back(predict_lift_step(step));
        step_clock_ms = step.now_ms;
    endtask

    task automatic write_reg(input logic [tlac_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [tlac_pkg::CFG_DATA_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            tlac_pkg::C_REG_CURRENT_LIMIT: lift_cfg.current_limit_ma    = value;
            tlac_pkg::C_REG_OC_HOLD:       lift_cfg.overcurrent_hold_ms = value;
            tlac_pkg::C_REG_MOVE_DURATION: lift_cfg.move_duration_ms    = value;
            tlac_pkg::C_REG_SETTLE_DELAY:  lift_cfg.settle_delay_ms     = value;
            tlac_pkg::C_REG_REVERSE_DIR:   lift_cfg.reverse_direction   = value[0];
            default: ;
        endcase
    endtask

    task automatic write_config(input tlac_pkg::t_cfg setting);
        write_reg(tlac_pkg::C_REG_CURRENT_LIMIT, setting.current_limit_ma);
        write_reg(tlac_pkg::C_REG_OC_HOLD, setting.overcurrent_hold_ms);
        write_reg(tlac_pkg::C_REG_MOVE_DURATION, setting.move_duration_ms);
        write_reg(tlac_pkg::C_REG_SETTLE_DELAY, setting.settle_delay_ms);
        write_reg(tlac_pkg::C_REG_REVERSE_DIR,
                  tlac_pkg::CFG_DATA_W'(setting.reverse_direction));
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_lift_idle();
        i_in_valid <= 1'b0;
        while (pending_lift_out.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // power-up state is an unfinished lower move from time 0
    task automatic test_power_up_move();
        send_step(step_item(32'd0, 16'd0, tlac_pkg::C_CMD_LOWER, 1'b0, 1'b0));
        send_step(step_item(32'd2000, 16'd400, tlac_pkg::C_CMD_LOWER, 1'b0, 1'b0));
        send_step(step_item(32'd2001, 16'd0, tlac_pkg::C_CMD_LOWER, 1'b0, 1'b0));
        send_step(step_item(32'd9000, 16'd0, tlac_pkg::C_CMD_LOWER, 1'b0, 1'b0));
        send_step(step_item(32'd9001, 16'd0, tlac_pkg::C_CMD_LOWER, 1'b0, 1'b0));
    endtask

    task automatic test_command_moves();
        send_step(step_item(32'd9500, 16'd0, tlac_pkg::C_CMD_RAISE, 1'b0, 1'b0));
        send_step(step_item(32'd9500, 16'd0, tlac_pkg::C_CMD_RAISE, 1'b0, 1'b0));
        send_step(step_item(32'd18501, 16'd0, tlac_pkg::C_CMD_RAISE, 1'b0, 1'b0));
        send_step(step_item(32'd18600, 16'd0, tlac_pkg::C_CMD_LOWER, 1'b0, 1'b0));
        // e-stop while driving reverts to raise
        send_step(step_item(32'd18700, 16'd0, tlac_pkg::C_CMD_LOWER, 1'b0, 1'b1));
        send_step(step_item(32'd18800, 16'd0, tlac_pkg::C_CMD_LOWER, 1'b0, 1'b0));
        send_step(step_item(32'd27701, 16'd0, tlac_pkg::C_CMD_LOWER, 1'b0, 1'b0));
        send_step(step_item(32'd27800, 16'd0, tlac_pkg::C_CMD_LOWER, 1'b1, 1'b0));
        // key-off ignored under e-stop, idle drive keeps the command
        send_step(step_item(32'd27900, 16'd0, tlac_pkg::C_CMD_LOWER, 1'b1, 1'b1));
        send_step(step_item(32'd28000, 16'd0, tlac_pkg::C_CMD_LOWER, 1'b0, 1'b1));
        send_step(step_item(32'd30001, 16'd0, tlac_pkg::C_CMD_LOWER, 1'b0, 1'b0));
    endtask

    task automatic test_field_extremes();
        send_step(step_item(32'd30100, 16'hFFFF, tlac_pkg::C_CMD_RAISE, 1'b1, 1'b1));
        send_step(step_item(32'd30200, 16'd0, tlac_pkg::C_CMD_RAISE, 1'b0, 1'b0));
        send_step(step_item(32'hFFFF_FFFF, 16'd0, tlac_pkg::C_CMD_LOWER, 1'b0, 1'b0));
        send_step(step_item(32'h0000_0010, 16'd0, tlac_pkg::C_CMD_LOWER, 1'b0, 1'b0));
        send_step(step_item(32'hFFFF_FFF0, 16'd0, tlac_pkg::C_CMD_LOWER, 1'b0, 1'b0));
        send_step(step_item(32'h0000_0005, 16'd0, tlac_pkg::C_CMD_RAISE, 1'b0, 1'b0));
    endtask

    task automatic test_random_steps(input int unsigned count);
        repeat (count) send_step(make_random_step());
    endtask

    // hold-time boundary, then the flag must stay set
    task automatic test_overcurrent_fault();
        logic [31:0] base_ms;
        base_ms = step_clock_ms + 32'd50;
        send_step(step_item(base_ms, 16'd400, tlac_pkg::C_CMD_RAISE, 1'b0, 1'b0));
        send_step(step_item(base_ms + 32'd1000, 16'd401, tlac_pkg::C_CMD_RAISE, 1'b0, 1'b0));
        send_step(step_item(base_ms + 32'd1001, 16'd401, tlac_pkg::C_CMD_RAISE, 1'b0, 1'b0));
        send_step(step_item(base_ms + 32'd1100, 16'd0, tlac_pkg::C_CMD_LOWER, 1'b0, 1'b0));
    endtask

    always @(posedge i_clk) begin
        tlac_pkg::t_out_item want;
        i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_lift_out.size() == 0) begin
                flag_mismatch("unexpected result", 0, 32'(o_out_data));
            end else begin
                want = pending_lift_out.pop_front();
                if (o_out_data.drive_code !== want.drive_code)
                    flag_mismatch("drive_code", 32'(want.drive_code),
                                  32'(o_out_data.drive_code));
                if (o_out_data.position_status !== want.position_status)
                    flag_mismatch("position_status", 32'(want.position_status),
                                  32'(o_out_data.position_status));
                if (o_out_data.overcurrent !== want.overcurrent)
                    flag_mismatch("overcurrent", 32'(want.overcurrent),
                                  32'(o_out_data.overcurrent));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 38;
        recv_idle_pct = 50;
        test_power_up_move();
        test_command_moves();
        test_field_extremes();
        wait_lift_idle();
        write_config(make_cfg(16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 1'b1));
        test_random_steps(170);
        wait_lift_idle();
        write_config(make_cfg(16'd1000, 16'd0, 16'hFFFF, 16'hFFFF, 1'b0));
        test_random_steps(170);

        send_idle_pct = 50;
        recv_idle_pct = 38;
        wait_lift_idle();
        write_config(make_cfg(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                              16'($urandom_range(65535)), 16'($urandom_range(65535)),
                              1'($urandom_range(1))));
        step_clock_ms = 32'hFFFF_0000;
        test_random_steps(170);
        wait_lift_idle();
        write_config(make_cfg(16'd3000, 16'd50, 16'd300, 16'd100, 1'b1));
        test_random_steps(170);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        wait_lift_idle();
        write_config(make_cfg(16'($urandom_range(20000)), 16'($urandom_range(5000)),
                              16'($urandom_range(20000)), 16'($urandom_range(20000)),
                              1'($urandom_range(1))));
        test_random_steps(170);
        wait_lift_idle();
        write_config(make_cfg(tlac_pkg::C_RST_CURRENT_LIMIT, tlac_pkg::C_RST_OC_HOLD,
                              tlac_pkg::C_RST_MOVE_DURATION, tlac_pkg::C_RST_SETTLE_DELAY,
                              1'b0));
        test_overcurrent_fault();
        wait_lift_idle();
        write_config(make_cfg(16'd0, 16'd0, 16'd5000, 16'd1000, 1'b0));
        fault_allowed = 1'b1;
        test_random_steps(180);

        wait_lift_idle();
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/tlac_pkg.sv
hw/rtl/tlac_step.sv
hw/rtl/timed_lift_actuator_controller_core.sv
sim/tb_timed_lift_actuator_controller_core.sv
